/* rtl/gbp_pkg.sv */
// Shared types and constants for the gshare branch predictor.
`timescale 1ns / 1ps

package gbp_pkg;

    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HISTORY_BITS = 2'd1;

    localparam logic [CFG_W-1:0] INDEX_BITS_RESET   = 4'd12;
    localparam logic [CFG_W-1:0] HISTORY_BITS_RESET = 4'd8;

    typedef struct packed {
        logic clear;
        logic load;
        logic update;
    } gbp_cmd_t;

    typedef struct packed {
        logic clear_done;
    } gbp_status_t;

endpackage

/* rtl/gbp_ctrl.sv */
// Controller state machine: table clear, item accept, update and result hold.
`timescale 1ns / 1ps

module gbp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  gbp_pkg::gbp_status_t status,
    output gbp_pkg::gbp_cmd_t   cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR  = 3'b001,
        ST_IDLE   = 3'b010,
        ST_UPDATE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   update_go;

    assign update_go = (state_reg == ST_UPDATE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (update_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (update_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign cmd.clear  = (state_reg == ST_CLEAR);
    assign cmd.load   = (state_reg == ST_IDLE) && in_valid;
    assign cmd.update = update_go;

endmodule

/* rtl/gbp_datapath.sv */
// Datapath: configuration, global history, counter table and prediction register.
`timescale 1ns / 1ps

module gbp_datapath #(
    parameter int MAX_INDEX_BITS = 12,
    parameter int CTR_WIDTH      = 2
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [gbp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gbp_pkg::CFG_W-1:0]     cfg_data,
    input  logic [31:0]                   branch_address,
    input  logic                          taken,
    output logic                          predict_taken,
    input  gbp_pkg::gbp_cmd_t             cmd,
    output gbp_pkg::gbp_status_t          status
);

    localparam int DEPTH = 1 << MAX_INDEX_BITS;
    localparam logic [CTR_WIDTH-1:0] CTR_HALF = CTR_WIDTH'(1) << (CTR_WIDTH - 1);
    localparam logic [CTR_WIDTH-1:0] CTR_MAX  = '1;

    logic [gbp_pkg::CFG_W-1:0]   index_bits_reg;
    logic [gbp_pkg::CFG_W-1:0]   history_bits_reg;
    logic [MAX_INDEX_BITS-1:0]   history_reg;
    logic [MAX_INDEX_BITS-1:0]   history_next;
    logic [MAX_INDEX_BITS-1:0]   clear_addr_reg;
    logic [MAX_INDEX_BITS-1:0]   idx_reg;
    logic [MAX_INDEX_BITS-1:0]   idx_next;
    logic                        taken_reg;
    logic [CTR_WIDTH-1:0]        rd_data_reg;
    logic [CTR_WIDTH-1:0]        ctr_next;
    logic                        pred_reg;
    logic [CTR_WIDTH-1:0]        table_mem [DEPTH];

    logic [gbp_pkg::CFG_W-1:0]   eff_index;
    logic [gbp_pkg::CFG_W-1:0]   eff_history;
    logic [MAX_INDEX_BITS-1:0]   imask;
    logic [MAX_INDEX_BITS-1:0]   hmask;
    logic [MAX_INDEX_BITS-1:0]   hist_top;
    logic [MAX_INDEX_BITS-1:0]   hist_masked;

    always_comb
    begin
        if (index_bits_reg == '0)
        begin
            eff_index = gbp_pkg::CFG_W'(1);
        end
        else if (32'(index_bits_reg) > MAX_INDEX_BITS)
        begin
            eff_index = gbp_pkg::CFG_W'(MAX_INDEX_BITS);
        end
        else
        begin
            eff_index = index_bits_reg;
        end
        eff_history = (history_bits_reg > eff_index) ? eff_index : history_bits_reg;
    end

    assign imask       = ~({MAX_INDEX_BITS{1'b1}} << eff_index);
    assign hmask       = ~({MAX_INDEX_BITS{1'b1}} << eff_history);
    assign hist_top    = hmask & ~(hmask >> 1);
    assign hist_masked = history_reg & hmask;
    assign idx_next    = (branch_address[MAX_INDEX_BITS+1:2] & imask) ^ hist_masked;
    assign history_next = ((hist_masked >> 1) | (taken_reg ? hist_top : '0)) & hmask;

    always_comb
    begin
        ctr_next = rd_data_reg;
        if (taken_reg)
        begin
            if (rd_data_reg != CTR_MAX)
            begin
                ctr_next = rd_data_reg + CTR_WIDTH'(1);
            end
        end
        else
        begin
            if (rd_data_reg != '0)
            begin
                ctr_next = rd_data_reg - CTR_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_bits_reg   <= gbp_pkg::INDEX_BITS_RESET;
            history_bits_reg <= gbp_pkg::HISTORY_BITS_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == gbp_pkg::REG_INDEX_BITS)
            begin
                index_bits_reg <= cfg_data;
            end
            else if (cfg_index == gbp_pkg::REG_HISTORY_BITS)
            begin
                history_bits_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            history_reg    <= '0;
            clear_addr_reg <= '0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clear_addr_reg <= clear_addr_reg + MAX_INDEX_BITS'(1);
            end
            if (cmd.update)
            begin
                history_reg <= history_next;
            end
        end
    end

    assign status.clear_done = cmd.clear && (clear_addr_reg == {MAX_INDEX_BITS{1'b1}});

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            idx_reg     <= idx_next;
            taken_reg   <= taken;
            rd_data_reg <= table_mem[idx_next];
        end
        if (cmd.clear)
        begin
            table_mem[clear_addr_reg] <= CTR_HALF;
        end
        else if (cmd.update)
        begin
            table_mem[idx_reg] <= ctr_next;
        end
        if (cmd.update)
        begin
            pred_reg <= (rd_data_reg >= CTR_HALF);
        end
    end

    assign predict_taken = pred_reg;

endmodule

/* rtl/gshare_branch_predictor.sv */
// Top level of the gshare / bimodal branch predictor.
`timescale 1ns / 1ps

// After reset the block sweeps all 2^MAX_INDEX_BITS entries of the counter table
// (4096 at the default) to weakly taken, one entry a cycle, and takes no item
// until the sweep ends; configuration writes are taken throughout. Each
// resolved branch then goes through accept and table read, then counter
// and history update with the table write, which loads the prediction into the
// output register. The prediction is offered from the cycle after the update
// and is held until taken; the block accepts the next item meanwhile, and that
// item waits in its update cycle while the previous result is still held. The
// block takes no new item until the previous one has finished its update, as
// the single-port counter table read-modify-write demands.
module gshare_branch_predictor #(
    parameter int MAX_INDEX_BITS = 12,
    parameter int CTR_WIDTH      = 2
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [gbp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gbp_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [31:0]                   branch_address,
    input  logic                          taken,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          predict_taken
);

    gbp_pkg::gbp_cmd_t    cmd;
    gbp_pkg::gbp_status_t status;

    gbp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    gbp_datapath #(
        .MAX_INDEX_BITS (MAX_INDEX_BITS),
        .CTR_WIDTH      (CTR_WIDTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .branch_address (branch_address),
        .taken          (taken),
        .predict_taken  (predict_taken),
        .cmd            (cmd),
        .status         (status)
    );

endmodule
